[design/dtsc_pkg.sv]
// Shared types and constants for the detection threshold, sort and cap unit.
`timescale 1ns / 1ps
package dtsc_pkg;

	localparam int LabW   = 3;
	localparam int ConfW  = 16;
	localparam int PixW   = 12;
	localparam int CapW   = 10;
	localparam int QW     = 18;
	localparam int CfgW   = 16;
	localparam int CfgIdxW = 2;

	localparam logic [QW-1:0] OneQ17 = 18'd131072;

	localparam logic [ConfW-1:0] ThrReset = 16'd32768;
	localparam logic [PixW-1:0]  WidReset = 12'd1936;
	localparam logic [PixW-1:0]  HgtReset = 12'd1094;
	localparam logic [CapW-1:0]  CapReset = 10'd99;

	localparam logic [CfgIdxW-1:0] RegThr = 2'd0;
	localparam logic [CfgIdxW-1:0] RegWid = 2'd1;
	localparam logic [CfgIdxW-1:0] RegHgt = 2'd2;
	localparam logic [CfgIdxW-1:0] RegCap = 2'd3;

	typedef struct packed {
		logic [LabW-1:0]  lab;
		logic [ConfW-1:0] conf;
		logic [PixW-1:0]  y_max;
		logic [PixW-1:0]  x_max;
		logic [PixW-1:0]  y_min;
		logic [PixW-1:0]  x_min;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic shl;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEEK,
		S_LOOK
	} rd_state_t;

endpackage

[design/detection_threshold_sort_cap_unit.sv]
// Top level: threshold and scale, sorted cell chain, capped drain sequencer.
// Insert: one transfer per cycle while in_stall is low; clamp in the transfer cycle, scale and insert in the next.
// Read: S_SEEK and S_LOOK shift out k chain entries (emitted or skipped), then register the result,
// one chain shift per cycle; a read waits for an empty result register and for the cycle
// after an insert transfer to pass.
// Reset (arst_n low, asynchronous): store empty, drop flag clear, registers to defaults.
`timescale 1ns / 1ps
module detection_threshold_sort_cap_unit import dtsc_pkg::*; #(
	parameter int MAX_ENTRIES = 1024,
	parameter int NUM_CLASSES = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]     cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [LabW-1:0]     class_label,
	input  logic [ConfW-1:0]    confidence,
	input  logic signed [17:0]  center_x,
	input  logic signed [17:0]  center_y,
	input  logic [16:0]         box_width,
	input  logic [16:0]         box_height,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                valid_res,
	output logic [LabW-1:0]     label,
	output logic [ConfW-1:0]    score,
	output logic [PixW-1:0]     x_min,
	output logic [PixW-1:0]     y_min,
	output logic [PixW-1:0]     x_max,
	output logic [PixW-1:0]     y_max,
	output logic                last,
	output logic                overflow
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [ConfW-1:0] thr_q;
	logic [PixW-1:0]  wid_q, hgt_q;
	logic [CapW-1:0]  cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ThrReset;
			wid_q <= WidReset;
			hgt_q <= HgtReset;
			cap_q <= CapReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegThr:  thr_q <= cfg_data;
				RegWid:  wid_q <= cfg_data[PixW-1:0];
				RegHgt:  hgt_q <= cfg_data[PixW-1:0];
				RegCap:  cap_q <= cfg_data[CapW-1:0];
				default: ;
			endcase
		end
	end

	rd_state_t        st_q, st_d;
	logic [CW-1:0]    count_q, count_d;
	logic             drop_q, drop_d;
	logic             have_prev_q, have_prev_d;
	logic [LabW-1:0]  prev_q, prev_d;
	logic [CapW-1:0]  emit_q, emit_d;
	logic             res_v_q, res_v_d;
	entry_t           res_q, res_d;
	logic             res_ok_q, res_ok_d;
	logic             res_last_q, res_last_d;
	logic             res_ovf_q, res_ovf_d;

	logic             ins_s1, ins_s2;
	logic [LabW-1:0]  lab_s1;
	logic [ConfW-1:0] conf_s1;
	logic [QW-1:0]    xl_s1, yl_s1, xh_s1, yh_s1;

	logic in_acc, ins_ok;
	assign in_stall = (st_q != S_IDLE) || (op && (ins_s1 || res_v_q));
	assign in_acc   = in_valid && !in_stall;
	assign ins_ok   = !op && ({1'b0, class_label} < 4'(NUM_CLASSES)) &&
		(confidence > thr_q) && !have_prev_q;

	function automatic logic [QW-1:0] clamp_q17(input logic signed [19:0] v);
		logic [QW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, OneQ17})) begin
			r = OneQ17;
		end else begin
			r = v[QW-1:0];
		end
		return r;
	endfunction

	logic signed [19:0] cx2, cy2, bw, bh;
	assign cx2 = $signed({center_x[17], center_x, 1'b0});
	assign cy2 = $signed({center_y[17], center_y, 1'b0});
	assign bw  = $signed({3'b000, box_width});
	assign bh  = $signed({3'b000, box_height});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_s1 <= 1'b0;
		end else begin
			ins_s1 <= in_acc && ins_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lab_s1  <= class_label;
			conf_s1 <= confidence;
			xl_s1   <= clamp_q17(cx2 - bw);
			yl_s1   <= clamp_q17(cy2 - bh);
			xh_s1   <= clamp_q17(cx2 + bw);
			yh_s1   <= clamp_q17(cy2 + bh);
		end
	end

	logic [QW+PixW-1:0] pxl, pyl, pxh, pyh;
	entry_t new_e;
	assign pxl = xl_s1 * wid_q;
	assign pyl = yl_s1 * hgt_q;
	assign pxh = xh_s1 * wid_q;
	assign pyh = yh_s1 * hgt_q;
	assign new_e = '{lab: lab_s1, conf: conf_s1,
		x_min: pxl[28:17], y_min: pyl[28:17], x_max: pxh[28:17], y_max: pyh[28:17]};
	assign ins_s2 = ins_s1 && (count_q != CW'(MAX_ENTRIES));

	cell_ctrl_t ctrl;
	entry_t     cells [MAX_ENTRIES];
	logic       bef   [MAX_ENTRIES];
	entry_t     head;
	assign head = cells[0];

	genvar g;
	generate
		for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
			entry_t le, re;
			logic   lb;
			if (g == 0) begin : g_first
				assign le = new_e;
				assign lb = 1'b1;
			end else begin : g_mid
				assign le = cells[g-1];
				assign lb = bef[g-1];
			end
			if (g == MAX_ENTRIES - 1) begin : g_end
				assign re = cells[g];
			end else begin : g_inner
				assign re = cells[g+1];
			end
			dtsc_cell #(.IDX(g), .CW(CW)) u_cell (
				.clk(clk), .ctrl(ctrl), .count(count_q), .new_e(new_e),
				.left_e(le), .left_before(lb), .right_e(re),
				.e(cells[g]), .ahead(bef[g])
			);
		end
	endgenerate

	logic [CapW-1:0] eff;
	assign eff = (have_prev_q && (prev_q == head.lab)) ? emit_q : '0;

	always_comb begin
		st_d        = st_q;
		count_d     = count_q;
		drop_d      = drop_q;
		have_prev_d = have_prev_q;
		prev_d      = prev_q;
		emit_d      = emit_q;
		res_v_d     = res_v_q && out_stall;
		res_d       = res_q;
		res_ok_d    = res_ok_q;
		res_last_d  = res_last_q;
		res_ovf_d   = res_ovf_q;
		ctrl        = '{ins: ins_s2, shl: 1'b0};
		if (ins_s1 && !ins_s2) begin
			drop_d = 1'b1;
		end
		if (ins_s2) begin
			count_d = count_q + 1'b1;
		end
		case (st_q)
			S_IDLE: begin
				if (in_acc && op) begin
					res_ovf_d = drop_q;
					st_d      = S_SEEK;
				end
			end
			S_SEEK, S_LOOK: begin
				if (count_q == '0) begin
					if (st_q == S_SEEK) begin
						res_d    = '0;
						res_ok_d = 1'b0;
					end
					res_last_d  = (st_q == S_LOOK);
					res_v_d     = 1'b1;
					count_d     = '0;
					have_prev_d = 1'b0;
					emit_d      = '0;
					drop_d      = 1'b0;
					st_d        = S_IDLE;
				end else if (eff < cap_q) begin
					if (st_q == S_SEEK) begin
						res_d       = head;
						res_ok_d    = 1'b1;
						emit_d      = eff + 1'b1;
						prev_d      = head.lab;
						have_prev_d = 1'b1;
						ctrl.shl    = 1'b1;
						count_d     = count_q - 1'b1;
						st_d        = S_LOOK;
					end else begin
						emit_d     = eff;
						res_last_d = 1'b0;
						res_v_d    = 1'b1;
						st_d       = S_IDLE;
					end
				end else begin
					emit_d      = eff;
					prev_d      = head.lab;
					have_prev_d = 1'b1;
					ctrl.shl    = 1'b1;
					count_d     = count_q - 1'b1;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			drop_q      <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			emit_q      <= '0;
			res_v_q     <= 1'b0;
		end else begin
			st_q        <= st_d;
			count_q     <= count_d;
			drop_q      <= drop_d;
			have_prev_q <= have_prev_d;
			prev_q      <= prev_d;
			emit_q      <= emit_d;
			res_v_q     <= res_v_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q      <= res_d;
		res_ok_q   <= res_ok_d;
		res_last_q <= res_last_d;
		res_ovf_q  <= res_ovf_d;
	end

	assign out_valid = res_v_q;
	assign valid_res = res_ok_q;
	assign label     = res_q.lab;
	assign score     = res_q.conf;
	assign x_min     = res_q.x_min;
	assign y_min     = res_q.y_min;
	assign x_max     = res_q.x_max;
	assign y_max     = res_q.y_max;
	assign last      = res_last_q;
	assign overflow  = res_ovf_q;

endmodule

[design/dtsc_cell.sv]
// One storage cell of the sorted chain: compare, insert, shift.
`timescale 1ns / 1ps
module dtsc_cell import dtsc_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 11
) (
	input  logic          clk,
	input  cell_ctrl_t    ctrl,
	input  logic [CW-1:0] count,
	input  entry_t        new_e,
	input  entry_t        left_e,
	input  logic          left_before,
	input  entry_t        right_e,
	output entry_t        e,
	output logic          ahead
);

	entry_t e_q;
	logic   valid;

	assign valid  = count > CW'(IDX);
	assign ahead  = valid && !((e_q.lab > new_e.lab) ||
		((e_q.lab == new_e.lab) && (e_q.conf < new_e.conf)));
	assign e = e_q;

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			e_q <= right_e;
		end else if (ctrl.ins) begin
			if (!left_before) begin
				e_q <= left_e;
			end else if (!ahead) begin
				e_q <= new_e;
			end
		end
	end

endmodule

[design/dtsc_checker.sv]
// Port-level checks for the detection threshold, sort and cap unit, with bind.
`timescale 1ns / 1ps
module dtsc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic op,
	input logic out_valid,
	input logic out_stall,
	input logic valid_res,
	input logic [2:0] label,
	input logic [15:0] score,
	input logic last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op |-> !out_valid)
		else $error("read transfer with result pending");

	a_last_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> valid_res)
		else $error("last flag on empty result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> (label == 3'd0) && (score == 16'd0))
		else $error("empty result carries data");

endmodule

bind detection_threshold_sort_cap_unit dtsc_checker u_dtsc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
	.out_valid(out_valid), .out_stall(out_stall), .valid_res(valid_res),
	.label(label), .score(score), .last(last)
);

[dv/testbench.sv]
// Self-checking testbench for the detection threshold, sort and cap unit.
`timescale 1ns / 1ps
module testbench;
	import dtsc_pkg::*;

	localparam int Depth   = 1024;
	localparam int Classes = 6;

	typedef struct {
		logic              op;
		logic [LabW-1:0]   lab;
		logic [ConfW-1:0]  conf;
		logic [17:0]       cx;
		logic [17:0]       cy;
		logic [16:0]       bw;
		logic [16:0]       bh;
	} cand_t;

	typedef struct {
		logic              vld;
		logic [LabW-1:0]   lab;
		logic [ConfW-1:0]  conf;
		logic [PixW-1:0]   x0;
		logic [PixW-1:0]   y0;
		logic [PixW-1:0]   x1;
		logic [PixW-1:0]   y1;
		logic              fin;
		logic              ovf;
	} det_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CfgIdxW-1:0] cfg_index = RegThr;
	logic [CfgW-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic op = 0;
	logic [LabW-1:0] class_label = '0;
	logic [ConfW-1:0] confidence = '0;
	logic signed [17:0] center_x = '0;
	logic signed [17:0] center_y = '0;
	logic [16:0] box_width = '0;
	logic [16:0] box_height = '0;
	logic out_valid;
	logic out_stall = 0;
	logic valid_res;
	logic [LabW-1:0] label;
	logic [ConfW-1:0] score;
	logic [PixW-1:0] x_min, y_min, x_max, y_max;
	logic last, overflow;

	detection_threshold_sort_cap_unit dut (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [ConfW-1:0] thr_r = ThrReset;
	logic [PixW-1:0] wid_r = WidReset;
	logic [PixW-1:0] hgt_r = HgtReset;
	logic [CapW-1:0] cap_r = CapReset;
	logic [LabW-1:0] lab_s [Depth];
	logic [ConfW-1:0] conf_s [Depth];
	logic [47:0] box_s [Depth];
	int n_stored = 0;
	int rd_ptr = 0;
	int emitted = 0;
	bit dropped = 0;

	cand_t pending[$];
	det_t expected_dets[$];
	cand_t cur;
	int in_gap = 0;
	int out_gap = 0;
	bit quiet = 0;
	int errors = 0;

	function automatic logic [PixW-1:0] pixel_of(longint q, logic [PixW-1:0] scl);
		longint c;
		if (q < 0) q = 0;
		if (q > 131072) q = 131072;
		c = (q * longint'(scl)) >>> 17;
		return c[PixW-1:0];
	endfunction

	function automatic void clear_store();
		n_stored = 0;
		rd_ptr = 0;
		emitted = 0;
		dropped = 0;
	endfunction

	function automatic void skip_capped();
		while (rd_ptr < n_stored) begin
			if (rd_ptr == 0 || lab_s[rd_ptr-1] != lab_s[rd_ptr])
				emitted = 0;
			if (emitted < cap_r)
				return;
			rd_ptr++;
		end
	endfunction

	function automatic void store_candidate(cand_t c);
		longint cx2, cy2, w, h;
		int pos;
		if (rd_ptr != 0 || c.lab >= Classes || c.conf <= thr_r)
			return;
		if (n_stored >= Depth) begin
			dropped = 1;
			return;
		end
		cx2 = 2 * longint'($signed(c.cx));
		cy2 = 2 * longint'($signed(c.cy));
		w = longint'(c.bw);
		h = longint'(c.bh);
		pos = 0;
		while (pos < n_stored && (lab_s[pos] < c.lab ||
				(lab_s[pos] == c.lab && conf_s[pos] >= c.conf)))
			pos++;
		for (int i = n_stored; i > pos; i--) begin
			lab_s[i] = lab_s[i-1];
			conf_s[i] = conf_s[i-1];
			box_s[i] = box_s[i-1];
		end
		lab_s[pos] = c.lab;
		conf_s[pos] = c.conf;
		box_s[pos] = {pixel_of(cy2 + h, hgt_r), pixel_of(cx2 + w, wid_r),
			pixel_of(cy2 - h, hgt_r), pixel_of(cx2 - w, wid_r)};
		n_stored++;
	endfunction

	function automatic det_t drain_next();
		det_t d;
		d = '{default: 0};
		d.ovf = dropped;
		skip_capped();
		if (rd_ptr >= n_stored) begin
			clear_store();
			return d;
		end
		d.vld = 1;
		d.lab = lab_s[rd_ptr];
		d.conf = conf_s[rd_ptr];
		{d.y1, d.x1, d.y0, d.x0} = box_s[rd_ptr];
		emitted++;
		rd_ptr++;
		skip_capped();
		if (rd_ptr >= n_stored) begin
			d.fin = 1;
			clear_store();
		end
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (cur.op)
					expected_dets.insert(expected_dets.size(), drain_next());
				else
					store_candidate(cur);
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 0;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					op <= cur.op;
					class_label <= cur.lab;
					confidence <= cur.conf;
					center_x <= cur.cx;
					center_y <= cur.cy;
					box_width <= cur.bw;
					box_height <= cur.bh;
					in_valid <= 1;
					if (!quiet && $urandom_range(0, 7) == 0)
						in_gap = $urandom_range(1, 12);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(0, 11);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		det_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_dets.size() == 0) begin
				$display("%0t: unexpected result label %0d score %0d", $time, label, score);
				errors++;
			end else begin
				e = expected_dets.pop_front();
				if (valid_res !== e.vld || label !== e.lab || score !== e.conf ||
						x_min !== e.x0 || y_min !== e.y0 || x_max !== e.x1 ||
						y_max !== e.y1 || last !== e.fin || overflow !== e.ovf) begin
					$display("%0t: mismatch expected v%0d l%0d s%0d (%0d,%0d)-(%0d,%0d) f%0d o%0d",
						$time, e.vld, e.lab, e.conf, e.x0, e.y0, e.x1, e.y1, e.fin, e.ovf);
					$display("%0t:            actual v%0d l%0d s%0d (%0d,%0d)-(%0d,%0d) f%0d o%0d",
						$time, valid_res, label, score, x_min, y_min, x_max, y_max,
						last, overflow);
					errors++;
				end
			end
		end
	end

	task automatic push(logic o, logic [LabW-1:0] l, logic [ConfW-1:0] c,
			logic [17:0] x, logic [17:0] y, logic [16:0] w, logic [16:0] h);
		cand_t t;
		t.op = o; t.lab = l; t.conf = c; t.cx = x; t.cy = y; t.bw = w; t.bh = h;
		pending.insert(pending.size(), t);
	endtask

	task automatic push_random_insert(bit over);
		logic [ConfW-1:0] c;
		c = over && thr_r != 16'hFFFF ? ConfW'($urandom_range(int'(thr_r) + 1, 65535))
			: ConfW'($urandom);
		if ($urandom_range(0, 3) == 0)
			c = thr_r + ConfW'($urandom_range(0, 1));
		push(1'b0, $urandom_range(0, 15) == 0 ? LabW'($urandom_range(6, 7))
			: LabW'($urandom_range(0, 5)), c,
			$urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 65536)),
			$urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 65536)),
			$urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 40000)),
			$urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 40000)));
	endtask

	task automatic push_read();
		push(1'b1, LabW'($urandom), ConfW'($urandom), 18'($urandom), 18'($urandom),
			17'($urandom), 17'($urandom));
	endtask

	task automatic settle();
		while (pending.size() > 0 || in_valid || expected_dets.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_regs(logic [ConfW-1:0] t, logic [PixW-1:0] w,
			logic [PixW-1:0] h, logic [CapW-1:0] m);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= RegThr; cfg_data <= t; thr_r = t;
		@(posedge clk);
		cfg_index <= RegWid; cfg_data <= CfgW'(w); wid_r = w;
		@(posedge clk);
		cfg_index <= RegHgt; cfg_data <= CfgW'(h); hgt_r = h;
		@(posedge clk);
		cfg_index <= RegCap; cfg_data <= CfgW'(m); cap_r = m;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase(int n);
		int k, r;
		k = 0;
		while (k < n) begin
			r = $urandom_range(1, 30);
			for (int i = 0; i < r; i++) push_random_insert($urandom_range(0, 4) != 0);
			k += r;
			r = $urandom_range(1, 12);
			for (int i = 0; i < r; i++) begin
				if ($urandom_range(0, 5) == 0) push_random_insert(1);
				else push_read();
			end
			k += r;
		end
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty read, extremes, ignored labels, threshold edge, equal keys
		push_read();
		push(1'b0, 3'd0, 16'hFFFF, 18'h20000, 18'h20000, 17'd0, 17'd0);
		push(1'b0, 3'd5, 16'd32769, 18'h1FFFF, 18'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		push(1'b0, 3'd6, 16'hFFFF, 18'd32768, 18'd32768, 17'd100, 17'd100);
		push(1'b0, 3'd7, 16'hFFFF, 18'd32768, 18'd32768, 17'd100, 17'd100);
		push(1'b0, 3'd2, 16'd32768, 18'd32768, 18'd32768, 17'd100, 17'd100);
		push(1'b0, 3'd2, 16'd0, 18'd32768, 18'd32768, 17'd100, 17'd100);
		push(1'b0, 3'd3, 16'd40000, 18'd30000, 18'd20000, 17'd5000, 17'd7000);
		push(1'b0, 3'd3, 16'd40000, 18'd50000, 18'd60000, 17'd9000, 17'd1000);
		push(1'b0, 3'd3, 16'd50000, 18'd65536, 18'd0, 17'h10000, 17'h10000);
		push_read();
		push(1'b0, 3'd1, 16'hFFFF, 18'd1000, 18'd1000, 17'd10, 17'd10);
		for (int i = 0; i < 6; i++) push_read();
		settle();

		write_regs(16'd0, 12'd1, 12'd1, 10'd0);
		random_phase(20);
		write_regs(16'hFFFF, 12'd4095, 12'd4095, 10'd1023);
		random_phase(15);
		write_regs(16'd0, 12'd4095, 12'd1, 10'd1);
		random_phase(25);

		// empty the store, fill past capacity, then drain with a cap of one
		for (int i = 0; i < 7; i++) push_read();
		for (int i = 0; i < Depth + 2; i++)
			push(1'b0, LabW'($urandom_range(0, 5)), ConfW'($urandom_range(1, 65535)),
				18'($urandom), 18'($urandom), 17'($urandom), 17'($urandom));
		for (int i = 0; i < 7; i++) push_read();
		settle();

		for (int p = 0; p < 2; p++) begin
			write_regs(ConfW'($urandom_range(0, 50000)), PixW'($urandom_range(1, 4095)),
				PixW'($urandom_range(1, 4095)), CapW'($urandom_range(0, 6)));
			random_phase(20);
		end
		quiet = 1;
		write_regs(16'd20000, 12'd1936, 12'd1216, 10'd99);
		random_phase(40);

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#400ms;
		$display("Verification failed");
		$finish;
	end
endmodule
